// ===== src/ple_pkg.sv =====
// shared types and codes for the positional list engine
package ple_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 10;
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 3;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef logic [2:0] act_t;
  localparam act_t ACT_NONE    = 3'd0;
  localparam act_t ACT_READ    = 3'd1;
  localparam act_t ACT_WRITE   = 3'd2;
  localparam act_t ACT_INS     = 3'd3;
  localparam act_t ACT_INS_END = 3'd4;
  localparam act_t ACT_DEL     = 3'd5;
  localparam act_t ACT_DEL_END = 3'd6;

  typedef struct packed {
    logic load;
    logic decide;
    logic up_step;
    logic dn_step;
    logic put;
    logic rd_chk;
    logic emit;
  } ple_cmd_t;

  typedef struct packed {
    act_t act;
    logic up_last;
    logic dn_last;
    logic out_free;
  } ple_sts_t;

endpackage

// ===== src/ple_ram.sv =====
// generic single write port ram with registered read
module ple_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ple_ctrl.sv =====
// controller state machine for the positional list engine
module ple_ctrl
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ple_sts_t sts,
  output ple_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        case (sts.act)
          ACT_READ: state_nxt = S_RD;
          ACT_INS:  state_nxt = S_UP;
          ACT_DEL:  state_nxt = S_DN;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_UP: begin
        cmd.up_step = 1'b1;
        if (sts.up_last) state_nxt = S_PUT;
      end
      S_DN: begin
        cmd.dn_step = 1'b1;
        if (sts.dn_last) state_nxt = S_DONE;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.rd_chk = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/ple_dp.sv =====
// datapath: operand registers, position decode, shift pointer, result register
module ple_dp
  import ple_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int DATA_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ple_cmd_t                        cmd,
  output ple_sts_t                        sts,
  input  logic [KIND_W-1:0]               in_kind,
  input  logic signed [POS_W-1:0]         in_position,
  input  logic [TYPE_W-1:0]               in_entry_type,
  input  logic [DATA_BITS-1:0]            in_entry_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic [$clog2(CAPACITY+1)-1:0]   out_count_after,
  output logic [TYPE_W-1:0]               out_found_type,
  output logic [DATA_BITS-1:0]            out_found_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = DATA_BITS + TYPE_W;
  localparam int SW = CW + POS_W + 1;

  logic [KIND_W-1:0]      kind_r;
  logic [POS_W-1:0]       pos_r;
  logic [TYPE_W-1:0]      type_r;
  logic [DATA_BITS-1:0]   data_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r;
  logic [CW-1:0]          ptr_r, ptr_nxt;
  logic [STATUS_W-1:0]    st_r;
  logic [TYPE_W-1:0]      ftype_r;
  logic [DATA_BITS-1:0]   fdata_r;
  logic                   out_valid_r;

  logic signed [SW-1:0]   p, cs, one_s, ins_i, acc_i;
  logic                   ins_ok, acc_ok, empty, full, at_end;
  act_t                   dec_act;
  logic [STATUS_W-1:0]    dec_st;
  logic [CW-1:0]          dec_idx;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [EW-1:0]          wdata, rdata;
  logic [EW-1:0]          new_entry;

  assign new_entry = {type_r, data_r};

  // position decode against the current count
  assign p      = SW'(signed'(pos_r));
  assign cs     = signed'(SW'(count_r));
  assign one_s  = signed'(SW'(1));
  assign ins_ok = (p <= cs) && (p >= -cs - one_s);
  assign acc_ok = (p < cs) && (p >= -cs);
  assign ins_i  = p[SW-1] ? (cs + one_s + p) : p;
  assign acc_i  = p[SW-1] ? (cs + p) : p;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CW'(CAPACITY));
  assign at_end = (p == cs) || (p == -cs - one_s);

  always_comb begin
    dec_act = ACT_NONE;
    dec_st  = ST_BADPOS;
    dec_idx = acc_i[CW-1:0];
    case (kind_r)
      KIND_APPEND: begin
        dec_idx = count_r;
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_st  = ST_OK;
          dec_act = ACT_INS_END;
        end
      end
      KIND_INSERT, KIND_SET: begin
        if (!ins_ok) begin
          dec_st = ST_BADPOS;
        end else if (kind_r == KIND_SET && !at_end) begin
          dec_st  = ST_OK;
          dec_act = ACT_WRITE;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_st  = ST_OK;
          dec_idx = ins_i[CW-1:0];
          dec_act = (ins_i[CW-1:0] == count_r) ? ACT_INS_END : ACT_INS;
        end
      end
      KIND_ERASE, KIND_FIND, KIND_UPDATE: begin
        if (empty) begin
          dec_st = ST_EMPTY;
        end else if (!acc_ok) begin
          dec_st = ST_BADPOS;
        end else begin
          dec_st = ST_OK;
          case (kind_r)
            KIND_ERASE:
              dec_act = (acc_i[CW-1:0] == count_r - CW'(1)) ? ACT_DEL_END : ACT_DEL;
            KIND_FIND: dec_act = ACT_READ;
            default:   dec_act = ACT_WRITE;
          endcase
        end
      end
      default: dec_st = ST_BADPOS;
    endcase
  end

  assign sts.act      = dec_act;
  assign sts.up_last  = (ptr_r == idx_r);
  assign sts.dn_last  = (ptr_r == count_r - CW'(1));
  assign sts.out_free = !out_valid_r || out_ready;

  // memory write and shift pointer
  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = new_entry;
    ptr_nxt = ptr_r;
    if (cmd.decide) begin
      case (dec_act)
        ACT_WRITE: begin
          we    = 1'b1;
          waddr = dec_idx[AW-1:0];
        end
        ACT_INS_END: begin
          we    = 1'b1;
          waddr = dec_idx[AW-1:0];
        end
        ACT_READ: ptr_nxt = dec_idx;
        ACT_INS:  ptr_nxt = count_r - CW'(1);
        ACT_DEL:  ptr_nxt = dec_idx + CW'(1);
        default:  ptr_nxt = ptr_r;
      endcase
    end
    if (cmd.up_step) begin
      we    = 1'b1;
      waddr = AW'(ptr_r + CW'(1));
      wdata = rdata;
      if (!sts.up_last) ptr_nxt = ptr_r - CW'(1);
    end
    if (cmd.dn_step) begin
      we    = 1'b1;
      waddr = AW'(ptr_r - CW'(1));
      wdata = rdata;
      if (!sts.dn_last) ptr_nxt = ptr_r + CW'(1);
    end
    if (cmd.put) begin
      we    = 1'b1;
      waddr = idx_r[AW-1:0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.decide && dec_act == ACT_INS_END) count_nxt = count_r + CW'(1);
    if (cmd.decide && dec_act == ACT_DEL_END) count_nxt = count_r - CW'(1);
    if (cmd.put) count_nxt = count_r + CW'(1);
    if (cmd.dn_step && sts.dn_last) count_nxt = count_r - CW'(1);
  end

  ple_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_nxt[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      kind_r  <= in_kind;
      pos_r   <= in_position;
      type_r  <= in_entry_type;
      data_r  <= in_entry_data;
      ftype_r <= '0;
      fdata_r <= '0;
    end
    if (cmd.decide) begin
      st_r  <= dec_st;
      idx_r <= dec_idx;
    end
    if (cmd.rd_chk) begin
      // stored type must match the expected one
      if (rdata[EW-1 -: TYPE_W] != type_r) begin
        st_r <= ST_MISMATCH;
      end else begin
        ftype_r <= rdata[EW-1 -: TYPE_W];
        fdata_r <= rdata[DATA_BITS-1:0];
      end
    end
    if (cmd.emit) begin
      out_status      <= st_r;
      out_count_after <= count_r;
      out_found_type  <= ftype_r;
      out_found_data  <= fdata_r;
    end
  end

  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status != ST_OK) |-> (out_found_type == '0 && out_found_data == '0))
    else $error("found entry reported on failed operation");

endmodule

// ===== src/positional_list_engine.sv =====
// positional list engine: one operation at a time; append, update, overwriting set, end
// insert, last-entry erase and any error pass from decode straight to the result, find
// adds a read and type check, insert before an entry shifts later entries up then writes,
// erase shifts them down, one entry moved per cycle; in_ready rises as the result loads;
// a waiting result beat stalls the following operation, though not its input, until out_ready
// reset (rst_n low, synchronous) empties the list and drops any pending result; ram not cleared
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int DATA_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [KIND_W-1:0]               in_kind,
  input  logic signed [POS_W-1:0]         in_position,
  input  logic [TYPE_W-1:0]               in_entry_type,
  input  logic [DATA_BITS-1:0]            in_entry_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic [$clog2(CAPACITY+1)-1:0]   out_count_after,
  output logic [TYPE_W-1:0]               out_found_type,
  output logic [DATA_BITS-1:0]            out_found_data
);

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_dp #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_entry_type   (in_entry_type),
    .in_entry_data   (in_entry_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_count_after (out_count_after),
    .out_found_type  (out_found_type),
    .out_found_data  (out_found_data)
  );

endmodule
